// ===== rtl/core/rpnsm_pkg.sv =====
// Package with opcodes, tags, error codes, sizes and divider request/response types for the RPN stack machine.
package rpnsm_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int DATA_DEPTH_DEF  = 1024;
  localparam int PROG_DEPTH_DEF  = 1024;

  localparam int OP_W   = 5;
  localparam int VAL_W  = 32;
  localparam int ADDR_W = 10;
  localparam int PC_W   = 11;
  localparam int ERR_W  = 3;
  localparam int TAG_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_NUM   = 5'd0,
    OP_VAR   = 5'd1,
    OP_ARR   = 5'd2,
    OP_READ  = 5'd3,
    OP_WRITE = 5'd4,
    OP_ADD   = 5'd5,
    OP_SUB   = 5'd6,
    OP_MUL   = 5'd7,
    OP_DIV   = 5'd8,
    OP_LT    = 5'd9,
    OP_ASN   = 5'd10,
    OP_GT    = 5'd11,
    OP_EQ    = 5'd12,
    OP_LE    = 5'd13,
    OP_GE    = 5'd14,
    OP_NE    = 5'd15,
    OP_JMP   = 5'd16,
    OP_JF    = 5'd17,
    OP_IDX   = 5'd18
  } op_t;

  typedef enum logic [TAG_W-1:0] {
    TAG_NUM = 2'd0,
    TAG_REF = 2'd1,
    TAG_ARR = 2'd2
  } tag_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 3'd0,
    ERR_UNDER = 3'd1,
    ERR_OVER  = 3'd2,
    ERR_DIV0  = 3'd3,
    ERR_ASN   = 3'd4,
    ERR_JUMP  = 3'd5,
    ERR_OPC   = 3'd6
  } err_t;

  typedef struct packed {
    logic              start;
    logic [VAL_W-1:0]  dividend;
    logic [VAL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [VAL_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== rtl/core/rpnsm_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rpnsm_div (
  input  logic                clk,
  input  logic                rst,
  input  rpnsm_pkg::div_req_t req,
  output rpnsm_pkg::div_rsp_t rsp
);
  import rpnsm_pkg::*;

  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] quo;
  logic [VAL_W-1:0] dvs;
  logic             neg;
  logic [5:0]       cnt;
  logic             busy;
  logic             done;
  logic [VAL_W:0]   trial;
  logic [VAL_W-1:0] rem_sh;

  always_comb begin
    rem_sh = {rem[VAL_W-2:0], quo[VAL_W-1]};
    trial  = {rem[VAL_W-1:0], quo[VAL_W-1]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= '0;
        quo  <= req.dividend[VAL_W-1] ? -req.dividend : req.dividend;
        dvs  <= req.divisor[VAL_W-1] ? -req.divisor : req.divisor;
        neg  <= req.dividend[VAL_W-1] ^ req.divisor[VAL_W-1];
      end else if (busy) begin
        if (!trial[VAL_W]) begin
          rem <= trial[VAL_W-1:0];
          quo <= {quo[VAL_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[VAL_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: (neg ? -quo : quo)};

endmodule

// ===== rtl/core/rpn_stack_machine_executor.sv =====
// Top level of the RPN stack machine executor.
// One input word carries one program element: opcode, literal, data address
// and the value for a read. Each accepted word gives exactly one output word
// with the next program counter, an optional write value and an error code.
// The operand stack and the data memory are synchronous RAMs with registered
// reads. Every element runs the same sequence: two stack reads, then two data
// memory reads one per cycle, then the result is formed and written back; a
// divide first waits in S_DIV for the bit-serial divider. The output word is
// loaded in S_OUT after S_SRD, S_OPB, S_OPA and S_EXEC, and the next input
// word is taken only once S_OUT has returned to S_IDLE, one element at a
// time. After reset the data memory is swept to zero while s_axis_tready
// stays low. Once the program counter reaches PROG_DEPTH, or an error halts
// the machine, every word gives next_pc = PROG_DEPTH and no other effect
// until reset. The output word sits in a register; while the receiver
// stalls, one more input word is taken and executed, and it then waits with
// s_axis_tready low until the output register is free.
module rpn_stack_machine_executor #(
  parameter int STACK_DEPTH = rpnsm_pkg::STACK_DEPTH_DEF,
  parameter int DATA_DEPTH  = rpnsm_pkg::DATA_DEPTH_DEF,
  parameter int PROG_DEPTH  = rpnsm_pkg::PROG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[4:0], literal_value[36:5], data_address[46:37], read_value[78:47]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[10:0], write_valid[11], write_value[43:12], error_code[46:44]
  output logic [47:0] m_axis_tdata
);
  import rpnsm_pkg::*;

  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int DW  = $clog2(DATA_DEPTH);
  localparam int PW  = $clog2(PROG_DEPTH + 1);
  localparam logic [PW-1:0] PEND = PW'(PROG_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SRD, S_OPB, S_OPA, S_EXEC, S_DIV, S_OUT
  } state_t;

  state_t state;

  logic [TAG_W+VAL_W-1:0] stk_mem [STACK_DEPTH];
  logic [VAL_W-1:0]       dmem    [DATA_DEPTH];

  logic [SPW-1:0] sp;
  logic [PW-1:0]  pc;
  logic [DW-1:0]  clr_addr;

  logic [OP_W-1:0]  op;
  logic [VAL_W-1:0] lit;
  logic [DW-1:0]    daddr;
  logic [VAL_W-1:0] rval;

  logic [SW-1:0]  stk_raddr;
  logic           stk_re;
  logic [TAG_W+VAL_W-1:0] stk_rdata;
  logic [SW-1:0]  stk_waddr;
  logic           stk_we;
  logic [TAG_W+VAL_W-1:0] stk_wdata;

  logic [DW-1:0]    dm_raddr;
  logic [VAL_W-1:0] dm_rdata;
  logic [DW-1:0]    dm_waddr;
  logic             dm_we;
  logic [VAL_W-1:0] dm_wdata;

  logic [TAG_W-1:0] tag_a, tag_b;
  logic [VAL_W-1:0] raw_a, raw_b, opa, opb, opa_q;
  logic [1:0]       need;
  logic [SW-1:0]    top_idx;

  logic [VAL_W-1:0] res;
  logic [PW-1:0]    o_pc;
  logic             o_wv;
  logic [VAL_W-1:0] o_wval;
  err_t             o_err;
  logic             halted;

  logic     div_start;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [VAL_W-1:0] mul_r;
  logic [VAL_W:0]   idx_sum;
  logic [DW-1:0]    idx_addr;

  rpnsm_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    dm_rdata <= dmem[dm_raddr];
  end

  always_comb begin
    unique case (op)
      OP_NUM, OP_VAR, OP_ARR: need = 2'd0;
      OP_READ, OP_WRITE, OP_JMP: need = 2'd1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_ASN, OP_GT, OP_EQ,
      OP_LE, OP_GE, OP_NE, OP_JF, OP_IDX: need = 2'd2;
      default: need = 2'd0;
    endcase
  end

  assign top_idx  = SW'(sp - SPW'(1));
  assign stk_re   = 1'b1;
  assign idx_sum  = {1'b0, raw_a} + {opb[VAL_W-1], opb};
  assign idx_addr = idx_sum[DW-1:0];
  assign mul_r    = opa * opb;

  // Stack read address: top in S_IDLE -> S_SRD, second below in S_SRD.
  always_comb begin
    stk_raddr = top_idx;
    if (state == S_SRD) stk_raddr = SW'(sp - SPW'(2));
  end

  always_comb begin
    dm_raddr = raw_b[DW-1:0];
    if (state == S_OPA) dm_raddr = raw_a[DW-1:0];
  end

  always_comb begin
    unique case (op)
      OP_ADD: res = opa + opb;
      OP_SUB: res = opa - opb;
      OP_MUL: res = mul_r;
      OP_LT:  res = VAL_W'($signed(opa) <  $signed(opb));
      OP_GT:  res = VAL_W'($signed(opa) >  $signed(opb));
      OP_EQ:  res = VAL_W'(opa == opb);
      OP_LE:  res = VAL_W'($signed(opa) <= $signed(opb));
      OP_GE:  res = VAL_W'($signed(opa) >= $signed(opb));
      OP_NE:  res = VAL_W'(opa != opb);
      default: res = div_rsp.quotient;
    endcase
  end

  assign halted = (pc >= PEND);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      sp            <= '0;
      pc            <= '0;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
      stk_we        <= 1'b0;
      dm_we         <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      stk_we    <= 1'b0;
      dm_we     <= 1'b0;
      div_start <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) m_axis_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          dm_we    <= 1'b1;
          dm_waddr <= clr_addr;
          dm_wdata <= '0;
          clr_addr <= clr_addr + DW'(1);
          if (clr_addr == DW'(DATA_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            op    <= s_axis_tdata[4:0];
            lit   <= s_axis_tdata[36:5];
            daddr <= DW'(s_axis_tdata[46:37]);
            rval  <= s_axis_tdata[78:47];
            state <= S_SRD;
          end
        end
        S_SRD: begin
          tag_b <= stk_rdata[TAG_W+VAL_W-1:VAL_W];
          raw_b <= stk_rdata[VAL_W-1:0];
          state <= S_OPB;
        end
        S_OPB: begin
          tag_a <= stk_rdata[TAG_W+VAL_W-1:VAL_W];
          raw_a <= stk_rdata[VAL_W-1:0];
          state <= S_OPA;
        end
        S_OPA: begin
          opb   <= (tag_b == TAG_NUM) ? raw_b : dm_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          opa_q  <= opa;
          o_wv   <= 1'b0;
          o_wval <= '0;
          o_err  <= ERR_OK;
          o_pc   <= pc + PW'(1);
          state  <= S_OUT;
          if (halted) begin
            o_pc <= PEND;
          end else if (sp < SPW'(need)) begin
            o_err <= ERR_UNDER;
          end else begin
            unique case (op)
              OP_NUM, OP_VAR, OP_ARR: begin
                if (sp >= SPW'(STACK_DEPTH)) o_err <= ERR_OVER;
                else begin
                  stk_we    <= 1'b1;
                  stk_waddr <= SW'(sp);
                  stk_wdata <= (op == OP_NUM) ? {TAG_NUM, lit} :
                               (op == OP_VAR) ? {TAG_REF, VAL_W'(daddr)} :
                                                {TAG_ARR, VAL_W'(daddr)};
                  sp        <= sp + SPW'(1);
                end
              end
              OP_READ: begin
                if (tag_b == TAG_NUM) o_err <= ERR_ASN;
                else begin
                  dm_we    <= 1'b1;
                  dm_waddr <= raw_b[DW-1:0];
                  dm_wdata <= rval;
                  sp       <= sp - SPW'(1);
                end
              end
              OP_WRITE: begin
                o_wv   <= 1'b1;
                o_wval <= opb;
                sp     <= sp - SPW'(1);
              end
              OP_ASN: begin
                if (tag_a == TAG_NUM) o_err <= ERR_ASN;
                else begin
                  dm_we    <= 1'b1;
                  dm_waddr <= raw_a[DW-1:0];
                  dm_wdata <= opb;
                  sp       <= sp - SPW'(2);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_LT, OP_GT, OP_EQ, OP_LE, OP_GE, OP_NE: begin
                stk_we    <= 1'b1;
                stk_waddr <= SW'(sp - SPW'(2));
                stk_wdata <= {TAG_NUM, res};
                sp        <= sp - SPW'(1);
              end
              OP_DIV: begin
                if (opb == '0) o_err <= ERR_DIV0;
                else begin
                  div_start <= 1'b1;
                  state     <= S_DIV;
                end
              end
              OP_JMP: begin
                if ($signed(opb) < 0 || opb > VAL_W'(PROG_DEPTH)) o_err <= ERR_JUMP;
                else begin
                  o_pc <= PW'(opb);
                  sp   <= sp - SPW'(1);
                end
              end
              OP_JF: begin
                if (opa == '0) begin
                  if ($signed(opb) < 0 || opb > VAL_W'(PROG_DEPTH)) o_err <= ERR_JUMP;
                  else begin
                    o_pc <= PW'(opb);
                    sp   <= sp - SPW'(2);
                  end
                end else sp <= sp - SPW'(2);
              end
              OP_IDX: begin
                if (tag_a == TAG_ARR) begin
                  stk_we    <= 1'b1;
                  stk_waddr <= SW'(sp - SPW'(2));
                  stk_wdata <= {TAG_REF, VAL_W'(idx_addr)};
                end
                sp <= sp - SPW'(1);
              end
              default: o_err <= ERR_OPC;
            endcase
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            stk_we    <= 1'b1;
            stk_waddr <= SW'(sp - SPW'(2));
            stk_wdata <= {TAG_NUM, div_rsp.quotient};
            sp        <= sp - SPW'(1);
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            if (o_err != ERR_OK) begin
              m_axis_tdata <= {1'b0, o_err, 32'd0, 1'b0, 11'(PEND)};
              pc           <= PEND;
            end else begin
              m_axis_tdata <= {1'b0, o_err, o_wval, o_wv, 11'(o_pc)};
              pc           <= o_pc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operand A comes from the second stack slot; in S_EXEC it is resolved
  // from the data word read during S_OPA, and a copy is held for the divider.
  assign opa = (tag_a == TAG_NUM) ? raw_a : dm_rdata;

  assign div_req       = '{start: div_start, dividend: opa_q, divisor: opb};
  assign s_axis_tready = (state == S_IDLE);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready)
    else $error("input taken while busy");
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer out of range");
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[46:44] != ERR_OK) |-> (pc == PEND))
    else $error("error did not halt");

endmodule
